// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file pkpd_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define PKPD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Antecedent in one cycle implies consequent in the same cycle.
`define PKPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication failed");

// Antecedent in one cycle implies consequent in the next cycle.
`define PKPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ----- hdl/pkpd_pkg.sv -----
// Types and constants of the power key press duration detector.
package pkpd_pkg;

  localparam int unsigned CntW = 9;
  localparam int unsigned ModeW = 3;
  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  localparam logic [CntW-1:0] CntMax = 9'd500;
  localparam logic [CntW-1:0] ShortReset = 9'd100;
  localparam logic [CntW-1:0] LongReset = 9'd300;

  localparam logic [ModeW-1:0] ScanStandby = 3'd0;
  localparam logic [ModeW-1:0] ScanRun2 = 3'd2;
  localparam logic [ModeW-1:0] ScanRun3 = 3'd3;
  localparam logic [ModeW-1:0] ScanForce = 3'd5;

  localparam logic [ModeW-1:0] ModeOn = 3'd1;
  localparam logic [ModeW-1:0] ModeAskOff = 3'd4;
  localparam logic [ModeW-1:0] ModeOff = 3'd6;

  typedef enum logic {
    REG_SHORT = 1'b0,
    REG_LONG  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [ModeW-1:0] scan_mode;
    logic [ModeW-1:0] current_work_mode;
    logic             power_key_down;
    logic             remote_on_down;
    logic             remote_off_down;
  } in_req_t;

  typedef struct packed {
    logic             mode_write;
    logic [ModeW-1:0] next_work_mode;
    logic             save_mode_write;
    logic [ModeW-1:0] saved_mode;
    logic             ask_shutdown_pulse;
  } out_req_t;

endpackage

// ----- hdl/power_key_press_duration_detector.sv -----
// Top level: press duration counters and work mode request logic.
//
//   channel | direction | handshake        | payload
//   in      | input     | in_valid/ready   | pkpd_pkg::in_req_t
//   out     | output    | out_valid/ready  | pkpd_pkg::out_req_t
//   cfg     | input     | APB psel/penable | short/long thresholds
//
// One request per cycle unless the output stalls; registers: input, then result.
// The compare and saturating increment of each counter sit between the two registers.
// Reset clears counters, valid flags and sets thresholds to 100 and 300.
// A stalled output holds the result; the input register still takes one more request.
module power_key_press_duration_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pkpd_pkg::in_req_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pkpd_pkg::out_req_t            out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pkpd_pkg::AddrW-1:0]    paddr,
  input  logic [pkpd_pkg::DataW-1:0]    pwdata,
  output logic [pkpd_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  logic [pkpd_pkg::CntW-1:0] short_q, long_q;
  logic [pkpd_pkg::CntW-1:0] pwr_cnt_q, pwr_cnt_d;
  logic [pkpd_pkg::CntW-1:0] ron_cnt_q, ron_cnt_d;
  logic [pkpd_pkg::CntW-1:0] roff_cnt_q, roff_cnt_d;
  logic                      in_valid_q;
  pkpd_pkg::in_req_t         in_q;
  logic                      out_valid_q;
  pkpd_pkg::out_req_t        out_q, out_d;
  logic                      advance;
  pkpd_pkg::reg_idx_e        reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = pkpd_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      pkpd_pkg::REG_SHORT: prdata = {{(pkpd_pkg::DataW-pkpd_pkg::CntW){1'b0}}, short_q};
      pkpd_pkg::REG_LONG:  prdata = {{(pkpd_pkg::DataW-pkpd_pkg::CntW){1'b0}}, long_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= pkpd_pkg::ShortReset;
      long_q  <= pkpd_pkg::LongReset;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        pkpd_pkg::REG_SHORT: short_q <= pwdata[pkpd_pkg::CntW-1:0];
        pkpd_pkg::REG_LONG:  long_q  <= pwdata[pkpd_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // saturating count while held, clear on release
  function automatic logic [pkpd_pkg::CntW-1:0] cnt_next(logic [pkpd_pkg::CntW-1:0] cnt,
                                                         logic down);
    logic [pkpd_pkg::CntW-1:0] res;
    if (!down) begin
      res = '0;
    end else if (cnt < pkpd_pkg::CntMax) begin
      res = cnt + 1'b1;
    end else begin
      res = pkpd_pkg::CntMax;
    end
    return res;
  endfunction

  always_comb begin
    logic                       pwr_fire_s, ron_fire_s, pwr_fire_l, roff_fire_l;
    logic [pkpd_pkg::ModeW-1:0] mode;
    pwr_fire_s  = !in_q.power_key_down && (pwr_cnt_q > short_q);
    ron_fire_s  = !in_q.remote_on_down && (ron_cnt_q > short_q);
    pwr_fire_l  = !in_q.power_key_down && (pwr_cnt_q > long_q);
    roff_fire_l = !in_q.remote_off_down && (roff_cnt_q > long_q);
    mode        = in_q.current_work_mode;
    pwr_cnt_d   = pwr_cnt_q;
    ron_cnt_d   = ron_cnt_q;
    roff_cnt_d  = roff_cnt_q;
    out_d       = '0;
    case (in_q.scan_mode)
      pkpd_pkg::ScanStandby: begin
        pwr_cnt_d = cnt_next(pwr_cnt_q, in_q.power_key_down);
        ron_cnt_d = cnt_next(ron_cnt_q, in_q.remote_on_down);
        if (pwr_fire_s || ron_fire_s) begin
          mode             = pkpd_pkg::ModeOn;
          out_d.mode_write = 1'b1;
        end
      end
      pkpd_pkg::ScanRun2, pkpd_pkg::ScanRun3: begin
        pwr_cnt_d  = cnt_next(pwr_cnt_q, in_q.power_key_down);
        roff_cnt_d = cnt_next(roff_cnt_q, in_q.remote_off_down);
        if (pwr_fire_l) begin
          mode             = pkpd_pkg::ModeOff;
          out_d.mode_write = 1'b1;
        end
        if (roff_fire_l) begin
          out_d.saved_mode         = mode;
          out_d.save_mode_write    = 1'b1;
          out_d.ask_shutdown_pulse = 1'b1;
          mode                     = pkpd_pkg::ModeAskOff;
          out_d.mode_write         = 1'b1;
        end
      end
      pkpd_pkg::ScanForce: begin
        pwr_cnt_d = cnt_next(pwr_cnt_q, in_q.power_key_down);
        if (pwr_fire_l) begin
          mode             = pkpd_pkg::ModeOff;
          out_d.mode_write = 1'b1;
        end
      end
      default: ;
    endcase
    out_d.next_work_mode = mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pwr_cnt_q   <= '0;
      ron_cnt_q   <= '0;
      roff_cnt_q  <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        pwr_cnt_q   <= pwr_cnt_d;
        ron_cnt_q   <= ron_cnt_d;
        roff_cnt_q  <= roff_cnt_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- hdl/pkpd_chk.sv -----
// Port-level checker for the power key press duration detector, with its bind.
`include "assert_macros.svh"

module pkpd_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input pkpd_pkg::out_req_t out_data_o
);

  `PKPD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))
  `PKPD_ASSERT_IMP(a_pulse_eq_save, clk_i, rst_ni, out_valid_o, out_data_o.ask_shutdown_pulse == out_data_o.save_mode_write)
  `PKPD_ASSERT_IMP(a_save_mode4, clk_i, rst_ni, out_valid_o && out_data_o.save_mode_write, out_data_o.mode_write && (out_data_o.next_work_mode == pkpd_pkg::ModeAskOff))
  `PKPD_ASSERT_IMP(a_plain_write, clk_i, rst_ni, out_valid_o && out_data_o.mode_write && !out_data_o.save_mode_write, (out_data_o.saved_mode == '0) && ((out_data_o.next_work_mode == pkpd_pkg::ModeOn) || (out_data_o.next_work_mode == pkpd_pkg::ModeOff)))

endmodule

bind power_key_press_duration_detector pkpd_chk u_pkpd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the power key press duration detector.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned LongHold = 300;
  localparam int unsigned DrainCycles = 4;
  localparam logic [pkpd_pkg::ModeW-1:0] IdleScans [4] = '{3'd1, 3'd4, 3'd6, 3'd7};

  typedef enum int {
    KEY_PWR  = 0,
    KEY_RON  = 1,
    KEY_ROFF = 2
  } key_e;

  typedef enum int {
    RDY_ALWAYS,
    RDY_RANDOM,
    RDY_SPARSE
  } ready_pattern_e;

  logic clk;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  pkpd_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pkpd_pkg::out_req_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pkpd_pkg::AddrW-1:0] paddr = '0;
  logic [pkpd_pkg::DataW-1:0] pwdata = '0;
  logic [pkpd_pkg::DataW-1:0] prdata;
  logic pready;

  pkpd_pkg::in_req_t tick_q[$];
  pkpd_pkg::out_req_t mode_update_q[$];

  logic [pkpd_pkg::CntW-1:0] press_cnt [3] = '{default: '0};
  logic [pkpd_pkg::CntW-1:0] short_thr = pkpd_pkg::ShortReset;
  logic [pkpd_pkg::CntW-1:0] long_thr = pkpd_pkg::LongReset;

  int err_cnt = 0;
  int pushed_cnt = 0;
  int results_seen = 0;
  int unsigned stall_cycles = 0;

  int gap_cnt = 0;
  int burst_left = 0;
  int hold_left = 0;
  int pat_left = 0;
  int pat_phase = 0;
  ready_pattern_e pat_kind = RDY_ALWAYS;

  power_key_press_duration_detector u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // count while held; judge against threshold and clear on release
  function automatic logic judge_press(key_e key, logic down, logic [pkpd_pkg::CntW-1:0] thr);
    logic fire;
    fire = 1'b0;
    if (down) begin
      if (press_cnt[key] < pkpd_pkg::CntMax) press_cnt[key] = press_cnt[key] + 1'b1;
      else press_cnt[key] = pkpd_pkg::CntMax;
    end else begin
      fire = press_cnt[key] > thr;
      press_cnt[key] = '0;
    end
    return fire;
  endfunction

  function automatic pkpd_pkg::out_req_t predict_mode_update(pkpd_pkg::in_req_t req);
    pkpd_pkg::out_req_t res;
    logic [pkpd_pkg::ModeW-1:0] mode;
    logic pwr_fire;
    logic ron_fire;
    res = '0;
    mode = req.current_work_mode;
    case (req.scan_mode)
      pkpd_pkg::ScanStandby: begin
        pwr_fire = judge_press(KEY_PWR, req.power_key_down, short_thr);
        ron_fire = judge_press(KEY_RON, req.remote_on_down, short_thr);
        if (pwr_fire || ron_fire) begin
          mode = pkpd_pkg::ModeOn;
          res.mode_write = 1'b1;
        end
      end
      pkpd_pkg::ScanRun2, pkpd_pkg::ScanRun3: begin
        if (judge_press(KEY_PWR, req.power_key_down, long_thr)) begin
          mode = pkpd_pkg::ModeOff;
          res.mode_write = 1'b1;
        end
        if (judge_press(KEY_ROFF, req.remote_off_down, long_thr)) begin
          res.saved_mode = mode;
          res.save_mode_write = 1'b1;
          res.ask_shutdown_pulse = 1'b1;
          mode = pkpd_pkg::ModeAskOff;
          res.mode_write = 1'b1;
        end
      end
      pkpd_pkg::ScanForce: begin
        if (judge_press(KEY_PWR, req.power_key_down, long_thr)) begin
          mode = pkpd_pkg::ModeOff;
          res.mode_write = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.next_work_mode = mode;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR at %0t: %s got %0d want %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // driver: bursts of requests with random gaps
  always @(posedge clk or negedge rst_n) begin
    logic nxt_valid;
    pkpd_pkg::in_req_t nxt_data;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      nxt_valid = in_valid;
      nxt_data = in_data;
      if (in_valid && in_ready) begin
        mode_update_q.push_back(predict_mode_update(in_data));
        void'(tick_q.pop_front());
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (tick_q.size() > 0) begin
          nxt_valid = 1'b1;
          nxt_data = tick_q[0];
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 19))
              0, 1, 2, 3, 4, 5: gap_cnt = 0;
              6: gap_cnt = $urandom_range(15, 25);
              default: gap_cnt = $urandom_range(1, 6);
            endcase
          end
        end
      end
      in_valid <= nxt_valid;
      in_data <= nxt_data;
    end
  end

  // monitor: checks results and drives the output stall pattern
  always @(posedge clk or negedge rst_n) begin
    pkpd_pkg::out_req_t want;
    logic nxt_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (mode_update_q.size() == 0) begin
          report_mismatch("result with no expectation", 1, 0);
        end else begin
          want = mode_update_q.pop_front();
          if (out_data.mode_write !== want.mode_write)
            report_mismatch("mode_write", out_data.mode_write, want.mode_write);
          if (out_data.next_work_mode !== want.next_work_mode)
            report_mismatch("next_work_mode", out_data.next_work_mode, want.next_work_mode);
          if (out_data.save_mode_write !== want.save_mode_write)
            report_mismatch("save_mode_write", out_data.save_mode_write, want.save_mode_write);
          if (out_data.saved_mode !== want.saved_mode)
            report_mismatch("saved_mode", out_data.saved_mode, want.saved_mode);
          if (out_data.ask_shutdown_pulse !== want.ask_shutdown_pulse)
            report_mismatch("ask_shutdown_pulse", out_data.ask_shutdown_pulse,
                            want.ask_shutdown_pulse);
        end
        if (results_seen == 150) hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else begin
        if (pat_left <= 0) begin
          pat_left = $urandom_range(10, 120);
          case ($urandom_range(0, 2))
            0: pat_kind = RDY_ALWAYS;
            1: pat_kind = RDY_RANDOM;
            default: pat_kind = RDY_SPARSE;
          endcase
        end
        pat_left--;
        pat_phase++;
        case (pat_kind)
          RDY_ALWAYS: nxt_ready = 1'b1;
          RDY_RANDOM: nxt_ready = 1'($urandom_range(0, 1));
          default: nxt_ready = (pat_phase % 4) == 0;
        endcase
      end
      out_ready <= nxt_ready;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("FAIL power_key_press_duration_detector");
    $finish;
  end

  task automatic push_tick(logic [pkpd_pkg::ModeW-1:0] scan, logic [pkpd_pkg::ModeW-1:0] mode,
                           logic pwr, logic ron, logic roff);
    pkpd_pkg::in_req_t t;
    t.scan_mode = scan;
    t.current_work_mode = mode;
    t.power_key_down = pwr;
    t.remote_on_down = ron;
    t.remote_off_down = roff;
    tick_q.push_back(t);
    pushed_cnt++;
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || mode_update_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_threshold(pkpd_pkg::reg_idx_e idx, logic [pkpd_pkg::CntW-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pkpd_pkg::AddrW'(idx) << 2;
    pwdata <= ($urandom() & ~32'h1FF) | pkpd_pkg::DataW'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == pkpd_pkg::REG_SHORT) short_thr = val;
    else long_thr = val;
  endtask

  task automatic hold_key(logic [pkpd_pkg::ModeW-1:0] scan, key_e key, int ticks);
    for (int i = 0; i < ticks; i++)
      push_tick(scan, 3'($urandom_range(0, 7)), key == KEY_PWR, key == KEY_RON,
                key == KEY_ROFF);
    push_tick(scan, 3'($urandom_range(0, 7)), 1'b0, 1'b0, 1'b0);
  endtask

  // one press: scan mode, key set held for a random length, then release
  task automatic press_sequence(int max_len);
    logic [pkpd_pkg::ModeW-1:0] scan;
    logic [pkpd_pkg::ModeW-1:0] mode;
    logic [2:0] keys;
    int len;
    bit broken;
    case ($urandom_range(0, 9))
      0, 1, 2: scan = pkpd_pkg::ScanStandby;
      3, 4: scan = pkpd_pkg::ScanRun2;
      5, 6: scan = pkpd_pkg::ScanRun3;
      7, 8: scan = pkpd_pkg::ScanForce;
      default: scan = IdleScans[$urandom_range(0, 3)];
    endcase
    mode = 3'($urandom_range(0, 7));
    keys = 3'($urandom_range(1, 7));
    len = $urandom_range(0, max_len);
    broken = $urandom_range(0, 9) == 0;
    for (int i = 0; i < len; i++) begin
      if (broken && i == len / 2) begin
        scan = 3'($urandom_range(0, 7));
        keys = keys & 3'($urandom_range(0, 7));
      end
      if ($urandom_range(0, 9) < 3) mode = 3'($urandom_range(0, 7));
      push_tick(scan, mode, keys[0], keys[1], keys[2]);
    end
    keys = keys & 3'($urandom_range(0, 7));
    if (keys != 0) push_tick(scan, mode, keys[0], keys[1], keys[2]);
    push_tick(scan, mode, 1'b0, 1'b0, 1'b0);
  endtask

  initial begin
    int start_cnt;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset short threshold: just above and exactly at
    hold_key(pkpd_pkg::ScanStandby, KEY_PWR, 101);
    hold_key(pkpd_pkg::ScanStandby, KEY_RON, 100);
    wait_drained();

    // directed
    write_threshold(pkpd_pkg::REG_SHORT, 9'd0);
    write_threshold(pkpd_pkg::REG_LONG, 9'd1);
    push_tick(pkpd_pkg::ScanStandby, 3'd0, 1'b1, 1'b0, 1'b0);
    push_tick(pkpd_pkg::ScanStandby, 3'd0, 1'b0, 1'b0, 1'b0);
    push_tick(pkpd_pkg::ScanStandby, 3'd7, 1'b0, 1'b1, 1'b0);
    push_tick(pkpd_pkg::ScanStandby, 3'd7, 1'b0, 1'b0, 1'b0);
    push_tick(pkpd_pkg::ScanStandby, 3'd0, 1'b1, 1'b1, 1'b1);
    push_tick(pkpd_pkg::ScanStandby, 3'd0, 1'b0, 1'b0, 1'b1);
    push_tick(pkpd_pkg::ScanRun2, 3'd7, 1'b1, 1'b0, 1'b1);
    push_tick(pkpd_pkg::ScanRun2, 3'd7, 1'b1, 1'b0, 1'b1);
    push_tick(pkpd_pkg::ScanRun2, 3'd7, 1'b0, 1'b0, 1'b0);
    push_tick(pkpd_pkg::ScanRun3, 3'd2, 1'b1, 1'b0, 1'b0);
    push_tick(pkpd_pkg::ScanRun3, 3'd2, 1'b0, 1'b0, 1'b0);
    push_tick(pkpd_pkg::ScanRun3, 3'd3, 1'b0, 1'b0, 1'b1);
    push_tick(pkpd_pkg::ScanRun3, 3'd3, 1'b0, 1'b0, 1'b1);
    push_tick(pkpd_pkg::ScanRun3, 3'd3, 1'b0, 1'b0, 1'b0);
    push_tick(pkpd_pkg::ScanForce, 3'd5, 1'b1, 1'b1, 1'b1);
    push_tick(pkpd_pkg::ScanForce, 3'd5, 1'b1, 1'b1, 1'b1);
    push_tick(pkpd_pkg::ScanForce, 3'd5, 1'b0, 1'b1, 1'b1);
    push_tick(pkpd_pkg::ScanRun2, 3'd0, 1'b0, 1'b0, 1'b0);
    push_tick(IdleScans[0], 3'd7, 1'b1, 1'b1, 1'b1);
    push_tick(IdleScans[1], 3'd0, 1'b1, 1'b1, 1'b1);
    push_tick(IdleScans[2], 3'd3, 1'b0, 1'b0, 1'b0);
    push_tick(IdleScans[3], 3'd7, 1'b1, 1'b1, 1'b1);
    push_tick(pkpd_pkg::ScanStandby, 3'd7, 1'b0, 1'b0, 1'b0);
    wait_drained();

    // random phases over several threshold settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin
          write_threshold(pkpd_pkg::REG_SHORT, 9'd0);
          write_threshold(pkpd_pkg::REG_LONG, 9'd0);
        end
        2: begin
          write_threshold(pkpd_pkg::REG_SHORT, 9'd500);
          write_threshold(pkpd_pkg::REG_LONG, 9'($urandom_range(0, 12)));
        end
        3: begin
          write_threshold(pkpd_pkg::REG_SHORT, 9'($urandom_range(0, 12)));
          write_threshold(pkpd_pkg::REG_LONG, 9'd511);
        end
        4: begin
          write_threshold(pkpd_pkg::REG_SHORT, 9'd511);
          write_threshold(pkpd_pkg::REG_LONG, 9'd500);
        end
        default: begin
          write_threshold(pkpd_pkg::REG_SHORT, 9'($urandom_range(0, 12)));
          write_threshold(pkpd_pkg::REG_LONG, 9'($urandom_range(0, 12)));
        end
      endcase
      start_cnt = pushed_cnt;
      while (pushed_cnt - start_cnt < 40) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 4))
            push_tick(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end else begin
          press_sequence(16);
        end
        if ($urandom_range(0, 29) == 0) wait_drained();
      end
      wait_drained();
    end

    wait_drained();
    repeat (6) @(posedge clk);
    if (err_cnt == 0) begin
      $display("PASS power_key_press_duration_detector");
    end else begin
      $display("FAIL power_key_press_duration_detector");
    end
    $finish;
  end

endmodule
